// ===== rtl/json_string_unescape_core_assert.svh =====
// Assertion macros for the JSON string unescaper.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef JSON_STRING_UNESCAPE_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_CORE_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// Shared types for the JSON string unescaper: parse phases, result codes,
// parser state and the result group passed from decoder to emitter.
`default_nettype none

package jsu_pkg;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_BODY    = 7'b0000010,
    PH_ESC     = 7'b0000100,
    PH_HEX1    = 7'b0001000,
    PH_WANT_BS = 7'b0010000,
    PH_WANT_U  = 7'b0100000,
    PH_HEX2    = 7'b1000000
  } phase_t;

  typedef enum logic [3:0] {
    ST_DATA      = 4'd0,
    ST_DONE      = 4'd1,
    ST_BAD_ESC   = 4'd2,
    ST_BAD_HEX   = 4'd3,
    ST_UNPAIRED  = 4'd4,
    ST_BAD_LOW   = 4'd5,
    ST_CONTROL   = 4'd6,
    ST_UNTERM    = 4'd7,
    ST_NO_QUOTE  = 4'd8
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  cnt;   // hex digits taken
    logic [15:0] acc;   // hex value so far
    logic [9:0]  hi;    // high surrogate minus 0xD800
  } st_t;

  // up to four results caused by one input request; byt[0] goes out first
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] byt;
    status_t         status;
  } grp_t;

endpackage

`default_nettype wire

// ===== rtl/json_string_unescape_core.sv =====
// JSON string unescaper, quoted text in, UTF-8 bytes and status codes out.
// The first result is presented in the cycle after the input request is taken.
// Takes one byte per cycle while out_tready is high; a byte giving several results holds
// input until its last result is taken (the result group register in jsu_emit is single-entry).
// Reset (rst_n low, synchronous): parser idle awaiting the opening quote, output empty.
// Depends on jsu_pkg, jsu_decode, jsu_emit and json_string_unescape_core_assert.svh.
`default_nettype none

`include "json_string_unescape_core_assert.svh"

module json_string_unescape_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [7:0]  in_tdata,    // [7:0] in_byte
  input  wire        in_tlast,    // in_end
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic [3:0] out_tuser,   // [3:0] out_status
  output logic       out_tlast
);

  jsu_pkg::st_t  st_r, st_nxt, st_dec;
  jsu_pkg::grp_t grp;
  logic          acc_req;
  logic          free;
  logic          load;
  logic          out_take;
  logic          is_status;
  logic          grp_busy;

  jsu_decode u_dec (
    .st_i   (st_r),
    .byte_i (in_tdata),
    .end_i  (in_tlast),
    .st_o   (st_dec),
    .grp_o  (grp)
  );

  assign in_tready = free;
  assign acc_req   = in_tvalid && in_tready;
  assign st_nxt    = acc_req ? st_dec : st_r;
  assign load      = acc_req && (grp.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{jsu_pkg::PH_IDLE, 2'd0, 16'd0, 10'd0};
    end else begin
      st_r <= st_nxt;
    end
  end

  jsu_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .grp_i      (grp),
    .free_o     (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign out_take  = out_tvalid && out_tready;
  assign is_status = out_tuser != jsu_pkg::ST_DATA;
  assign grp_busy  = out_tvalid && !(out_tready && out_tlast);

  // status results always stand alone
  `JSU_ASSERT_IMP(a_status_single, out_tvalid && is_status, out_tlast, "status not last")
  // a request with results shows a result next cycle
  `JSU_ASSERT_NXT(a_load_shows, load, out_tvalid, "accepted results not presented")
  // a taken non-last result is followed by more data of the same group
  `JSU_ASSERT_NXT(a_group_cont, out_take && !out_tlast, out_tvalid && !is_status, "group cut short")
  // no new request while a group still has results to send
  `JSU_ASSERT_IMP(a_no_overrun, grp_busy, !in_tready, "input overran group")

endmodule

`default_nettype wire

// ===== rtl/jsu_decode.sv =====
// Next-state and result-group logic for one input byte.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
  input  wire jsu_pkg::st_t  st_i,
  input  wire [7:0]          byte_i,
  input  wire                end_i,
  output jsu_pkg::st_t       st_o,
  output jsu_pkg::grp_t      grp_o
);

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic jsu_pkg::grp_t utf8(input logic [20:0] cp);
    jsu_pkg::grp_t g;
    g = '0;
    g.status = jsu_pkg::ST_DATA;
    if (cp < 21'h80) begin
      g.cnt    = 3'd1;
      g.byt[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      g.cnt    = 3'd2;
      g.byt[0] = {3'b110, cp[10:6]};
      g.byt[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      g.cnt    = 3'd3;
      g.byt[0] = {4'b1110, cp[15:12]};
      g.byt[1] = {2'b10, cp[11:6]};
      g.byt[2] = {2'b10, cp[5:0]};
    end else begin
      g.cnt    = 3'd4;
      g.byt[0] = {5'b11110, cp[20:18]};
      g.byt[1] = {2'b10, cp[17:12]};
      g.byt[2] = {2'b10, cp[11:6]};
      g.byt[3] = {2'b10, cp[5:0]};
    end
    return g;
  endfunction

  logic [4:0]  hv;
  logic [15:0] acc_new;
  logic [10:0] plane;

  assign hv      = hex_val(byte_i);
  assign acc_new = {st_i.acc[11:0], hv[3:0]};
  assign plane   = {1'b0, st_i.hi} + 11'd64;   // 0x10000 >> 10

  always_comb begin
    logic fail;
    jsu_pkg::status_t code;
    fail  = 1'b0;
    code  = jsu_pkg::ST_DATA;
    st_o  = st_i;
    grp_o = '0;
    grp_o.status = jsu_pkg::ST_DATA;

    unique case (st_i.phase)
      jsu_pkg::PH_BODY: begin
        if (end_i) begin
          fail = 1'b1; code = jsu_pkg::ST_UNTERM;
        end else if (byte_i == 8'h22) begin
          fail = 1'b1; code = jsu_pkg::ST_DONE;
        end else if (byte_i == 8'h5C) begin
          st_o.phase = jsu_pkg::PH_ESC;
        end else if (byte_i < 8'h20) begin
          fail = 1'b1; code = jsu_pkg::ST_CONTROL;
        end else begin
          grp_o.cnt    = 3'd1;
          grp_o.byt[0] = byte_i;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (end_i) begin
          fail = 1'b1; code = jsu_pkg::ST_UNTERM;
        end else begin
          st_o.phase = jsu_pkg::PH_BODY;
          grp_o.cnt  = 3'd1;
          case (byte_i)
            8'h22, 8'h5C, 8'h2F: grp_o.byt[0] = byte_i;
            8'h62: grp_o.byt[0] = 8'h08;
            8'h66: grp_o.byt[0] = 8'h0C;
            8'h6E: grp_o.byt[0] = 8'h0A;
            8'h72: grp_o.byt[0] = 8'h0D;
            8'h74: grp_o.byt[0] = 8'h09;
            8'h75: begin
              grp_o.cnt  = 3'd0;
              st_o.phase = jsu_pkg::PH_HEX1;
              st_o.cnt   = 2'd0;
              st_o.acc   = 16'd0;
            end
            default: begin
              fail = 1'b1; code = jsu_pkg::ST_BAD_ESC;
            end
          endcase
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (end_i) begin
          fail = 1'b1; code = jsu_pkg::ST_UNTERM;
        end else if (!hv[4]) begin
          fail = 1'b1; code = jsu_pkg::ST_BAD_HEX;
        end else if (st_i.cnt != 2'd3) begin
          st_o.acc = acc_new;
          st_o.cnt = st_i.cnt + 2'd1;
        end else begin
          st_o.cnt = 2'd0;
          st_o.acc = 16'd0;
          if (st_i.phase == jsu_pkg::PH_HEX1) begin
            if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
              st_o.hi    = acc_new[9:0];
              st_o.phase = jsu_pkg::PH_WANT_BS;
            end else begin
              st_o.phase = jsu_pkg::PH_BODY;
              grp_o      = utf8({5'd0, acc_new});
            end
          end else if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
            fail = 1'b1; code = jsu_pkg::ST_BAD_LOW;
          end else begin
            st_o.phase = jsu_pkg::PH_BODY;
            grp_o      = utf8({plane, acc_new[9:0]});
          end
        end
      end
      jsu_pkg::PH_WANT_BS: begin
        if (end_i) begin
          fail = 1'b1; code = jsu_pkg::ST_UNTERM;
        end else if (byte_i != 8'h5C) begin
          fail = 1'b1; code = jsu_pkg::ST_UNPAIRED;
        end else begin
          st_o.phase = jsu_pkg::PH_WANT_U;
        end
      end
      jsu_pkg::PH_WANT_U: begin
        if (end_i) begin
          fail = 1'b1; code = jsu_pkg::ST_UNTERM;
        end else if (byte_i != 8'h75) begin
          fail = 1'b1; code = jsu_pkg::ST_UNPAIRED;
        end else begin
          st_o.phase = jsu_pkg::PH_HEX2;
          st_o.cnt   = 2'd0;
          st_o.acc   = 16'd0;
        end
      end
      default: begin
        // idle, and any stray phase code
        if (!end_i && byte_i == 8'h22) begin
          st_o.phase = jsu_pkg::PH_BODY;
          st_o.cnt   = 2'd0;
          st_o.acc   = 16'd0;
        end else begin
          fail = 1'b1; code = jsu_pkg::ST_NO_QUOTE;
        end
      end
    endcase

    if (fail) begin
      st_o.phase   = jsu_pkg::PH_IDLE;
      st_o.cnt     = 2'd0;
      st_o.acc     = 16'd0;
      grp_o        = '0;
      grp_o.cnt    = 3'd1;
      grp_o.status = code;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsu_emit.sv =====
// Result group register and serialiser: sends one result per cycle while out_tready is high.
// Depends on jsu_pkg.
`default_nettype none

module jsu_emit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load_i,
  input  wire jsu_pkg::grp_t  grp_i,
  output logic                free_o,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [7:0]          out_tdata,   // [7:0] out_byte
  output logic [3:0]          out_tuser,   // [3:0] out_status
  output logic                out_tlast
);

  logic          vld_r, vld_nxt;
  logic [1:0]    idx_r, idx_nxt;
  jsu_pkg::grp_t grp_r;
  logic          last;

  assign last       = ({1'b0, idx_r} + 3'd1) == grp_r.cnt;
  assign free_o     = !vld_r || (out_tready && last);
  assign out_tvalid = vld_r;
  assign out_tdata  = grp_r.byt[idx_r];
  assign out_tuser  = grp_r.status;
  assign out_tlast  = last;

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (vld_r && out_tready) begin
      if (last) vld_nxt = 1'b0;
      else      idx_nxt = idx_r + 2'd1;
    end
    if (load_i) begin
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) grp_r <= grp_i;
  end

endmodule

`default_nettype wire
